FILE: hw/rtl/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg
// shared widths, types and index tables for the point in triangle test
// ----------------------------------------------------------------------------
package pit_pkg;

    localparam int COORD_W  = 16;
    localparam int NUM_CRD  = 12;
    localparam int IN_W     = ((NUM_CRD * COORD_W + 7) / 8) * 8;
    localparam int OUT_W    = 8;

    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int CRS_W    = PROD_W + 1;
    localparam int LO_W     = CRS_W / 2;
    localparam int HI_W     = CRS_W - LO_W;
    localparam int PLO_W    = CRS_W + LO_W + 1;
    localparam int PHI_W    = CRS_W + HI_W;
    localparam int TERM_W   = 2 * CRS_W;
    localparam int DOT_W    = TERM_W + 2;

    localparam int NSTG     = 6;

    // vertex slots in the input beat
    localparam int VTX_P    = 0;
    localparam int VTX_A    = 1;
    localparam int VTX_B    = 2;
    localparam int VTX_C    = 3;

    // start and end vertex of each edge
    localparam int EDGE_BEG [3] = '{VTX_A, VTX_B, VTX_C};
    localparam int EDGE_END [3] = '{VTX_B, VTX_C, VTX_A};

    // component pairs of a cross product
    localparam int CRS_J [3] = '{1, 2, 0};
    localparam int CRS_K [3] = '{2, 0, 1};

    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [CRS_W-1:0]  t_crs;
    typedef logic signed [PLO_W-1:0]  t_plo;
    typedef logic signed [PHI_W-1:0]  t_phi;
    typedef logic signed [TERM_W-1:0] t_term;
    typedef logic signed [DOT_W-1:0]  t_dot;

endpackage

FILE: hw/rtl/point_in_triangle_test.sv
// ----------------------------------------------------------------------------
// point_in_triangle_test
// same-side test of a 3d point against a triangle, exact fixed-point math
//
//  port group   dir  beat contents
//  i_s_*        in   pt_x pt_y pt_z va_x va_y va_z vb_x vb_y vb_z vc_x vc_y vc_z
//  o_m_*        out  inside_res
//
//  one beat per cycle sustained unless the output side stalls
//  six register stages: differences, cross products, cross sums, split dot
//  products, partial sums, output register holding the sign test
//  each stage loads when it is empty or the stage after it moves on
//  stall on the output side fills bubbles first, then holds o_s_tready low
//  synchronous active-low reset clears all stage valid bits
// ----------------------------------------------------------------------------
module point_in_triangle_test (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // pt_x, pt_y, pt_z, va_x, va_y, va_z, vb_x, vb_y, vb_z, vc_x, vc_y, vc_z
    input  logic [pit_pkg::IN_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // inside_res, zero padding
    output logic [pit_pkg::OUT_W-1:0] o_m_tdata
);
    import pit_pkg::*;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] ld_stg;

    t_diff r_edge [3][3];
    t_diff r_rel  [3][3];
    t_diff n_edge [3][3];
    t_diff n_rel  [3][3];

    t_prod r_pa [4][3];
    t_prod r_pb [4][3];
    t_prod n_pa [4][3];
    t_prod n_pb [4][3];

    t_crs  r_crs [4][3];
    t_crs  n_crs [4][3];

    t_plo  r_lo [3][3];
    t_phi  r_hi [3][3];
    t_plo  n_lo [3][3];
    t_phi  n_hi [3][3];

    t_term r_term [3][3];
    t_term n_term [3][3];

    logic  r_inside;
    logic  n_inside;

    // stage load enables, last stage first
    always_comb begin
        ld_stg[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            ld_stg[s] = !r_vld[s] || ld_stg[s+1];
        end
    end

    assign o_s_tready = ld_stg[0];
    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = {{(OUT_W-1){1'b0}}, r_inside};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld_stg[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (ld_stg[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // stage 1: edge vectors and point relative to each edge start
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                n_edge[i][k] =
                    DIFF_W'($signed(i_s_tdata[(EDGE_END[i]*3 + k)*COORD_W +: COORD_W]))
                  - DIFF_W'($signed(i_s_tdata[(EDGE_BEG[i]*3 + k)*COORD_W +: COORD_W]));
                n_rel[i][k] =
                    DIFF_W'($signed(i_s_tdata[(VTX_P*3 + k)*COORD_W +: COORD_W]))
                  - DIFF_W'($signed(i_s_tdata[(EDGE_BEG[i]*3 + k)*COORD_W +: COORD_W]));
            end
        end
    end

    // stage 2: cross product terms, set 0 is the normal
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_pa[0][k] = r_edge[0][CRS_J[k]] * r_edge[1][CRS_K[k]];
            n_pb[0][k] = r_edge[0][CRS_K[k]] * r_edge[1][CRS_J[k]];
            for (int i = 0; i < 3; i++) begin
                n_pa[i+1][k] = r_edge[i][CRS_J[k]] * r_rel[i][CRS_K[k]];
                n_pb[i+1][k] = r_edge[i][CRS_K[k]] * r_rel[i][CRS_J[k]];
            end
        end
    end

    // stage 3: cross products
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 3; k++) begin
                n_crs[c][k] = CRS_W'(r_pa[c][k]) - CRS_W'(r_pb[c][k]);
            end
        end
    end

    // stage 4: dot product terms, normal split in low and high halves
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                n_lo[i][k] = r_crs[i+1][k] * $signed({1'b0, r_crs[0][k][LO_W-1:0]});
                n_hi[i][k] = r_crs[i+1][k] * $signed(r_crs[0][k][CRS_W-1:LO_W]);
            end
        end
    end

    // stage 5: recombine halves
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                n_term[i][k] = (TERM_W'(r_hi[i][k]) <<< LO_W) + TERM_W'(r_lo[i][k]);
            end
        end
    end

    // stage 6: dot sums and sign test
    always_comb begin
        t_dot dot;
        n_inside = 1'b1;
        for (int i = 0; i < 3; i++) begin
            dot = DOT_W'(r_term[i][0]) + DOT_W'(r_term[i][1]) + DOT_W'(r_term[i][2]);
            if (dot[DOT_W-1]) begin
                n_inside = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_stg[0]) begin
            r_edge <= n_edge;
            r_rel  <= n_rel;
        end
        if (ld_stg[1]) begin
            r_pa <= n_pa;
            r_pb <= n_pb;
        end
        if (ld_stg[2]) begin
            r_crs <= n_crs;
        end
        if (ld_stg[3]) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (ld_stg[4]) begin
            r_term <= n_term;
        end
        if (ld_stg[5]) begin
            r_inside <= n_inside;
        end
    end

endmodule

FILE: hw/rtl/pit_checker.sv
// ----------------------------------------------------------------------------
// pit_checker
// port-level checks for the point in triangle test, bound to the top level
// ----------------------------------------------------------------------------
module pit_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_s_tready,
    input logic                       o_m_tvalid,
    input logic                       i_m_tready,
    input logic [pit_pkg::OUT_W-1:0]  o_m_tdata
);
    import pit_pkg::*;

    // no result beat right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat after reset");

    // stalled result beat keeps its value
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("stalled result changed");

    // padding above the result bit stays zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[OUT_W-1:1] == '0)
        else $error("result padding not zero");

    // nothing can back up while the output stage is empty
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // input stalls only when a result waits and is not taken
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input stalled without output backpressure");

endmodule

bind point_in_triangle_test pit_checker u_pit_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: tb/sv/point_in_triangle_check.sv
// ----------------------------------------------------------------------------
// point_in_triangle_check
// watches the input and result streams of the point in triangle test, works
// out the inside flag of every accepted input beat with exact wide arithmetic
// and compares it, in order, with the accepted result beats
// ----------------------------------------------------------------------------
module point_in_triangle_check (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    // pt_x, pt_y, pt_z, va_x, va_y, va_z, vb_x, vb_y, vb_z, vc_x, vc_y, vc_z
    input  logic [pit_pkg::IN_W-1:0]  i_s_tdata,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    // inside_res, zero padding
    input  logic [pit_pkg::OUT_W-1:0] i_m_tdata,
    output int                        o_fail_cnt,
    output int                        o_pending
);
    import pit_pkg::*;

    typedef logic signed [127:0] t_exact;

    bit inside_q [$];
    int fail_cnt = 0;
    int res_cnt  = 0;

    assign o_fail_cnt = fail_cnt;

    function automatic bit predict_inside(input logic [IN_W-1:0] beat);
        t_exact crd [4][3];
        t_exact edg [3][3];
        t_exact nrm [3];
        t_exact rel [3];
        t_exact crs [3];
        t_exact dotp;
        int     beg;
        int     fin;
        int     j;
        int     l;
        for (int v = 0; v < 4; v++)
            for (int k = 0; k < 3; k++)
                crd[v][k] = $signed(beat[(v*3+k)*COORD_W +: COORD_W]);
        // edges a->b, b->c, c->a
        for (int i = 0; i < 3; i++) begin
            beg = VTX_A + i;
            fin = VTX_A + (i + 1) % 3;
            for (int k = 0; k < 3; k++)
                edg[i][k] = crd[fin][k] - crd[beg][k];
        end
        for (int k = 0; k < 3; k++) begin
            j = (k + 1) % 3;
            l = (k + 2) % 3;
            nrm[k] = edg[0][j] * edg[1][l] - edg[0][l] * edg[1][j];
        end
        for (int i = 0; i < 3; i++) begin
            beg = VTX_A + i;
            for (int k = 0; k < 3; k++)
                rel[k] = crd[VTX_P][k] - crd[beg][k];
            for (int k = 0; k < 3; k++) begin
                j = (k + 1) % 3;
                l = (k + 2) % 3;
                crs[k] = edg[i][j] * rel[l] - edg[i][l] * rel[j];
            end
            dotp = '0;
            for (int k = 0; k < 3; k++)
                dotp += crs[k] * nrm[k];
            if (dotp < 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                if (inside_q.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("%0t: result beat %0d with no input outstanding, got %h",
                                 $time, res_cnt, i_m_tdata);
                    fail_cnt++;
                end else begin
                    want = OUT_W'(inside_q.pop_front());
                    if (i_m_tdata !== want) begin
                        if (fail_cnt < 10)
                            $display("%0t: result beat %0d expected %h got %h",
                                     $time, res_cnt, want, i_m_tdata);
                        fail_cnt++;
                    end
                end
                res_cnt++;
            end
            if (i_s_tvalid && i_s_tready)
                inside_q.push_back(predict_inside(i_s_tdata));
        end
        o_pending <= inside_q.size();
    end

endmodule

FILE: tb/sv/tb_point_in_triangle_test.sv
// ----------------------------------------------------------------------------
// tb_point_in_triangle_test
// drives point and triangle beats into the block, first hand-picked shapes
// (edges, vertices, degenerate and off-plane cases, range extremes), then
// random shapes under four idle and stall mixes with one long output hold;
// the checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module tb_point_in_triangle_test;
    import pit_pkg::*;

    localparam int CRD_MAX        = 2**(COORD_W-1) - 1;
    localparam int CRD_MIN        = -(2**(COORD_W-1));
    localparam int HOLD_CYC       = 300;
    localparam int LIMIT_CYC      = 200000;
    localparam int RAND_PER_PHASE = 213;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata  = '0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;

    int   fail_cnt;
    int   pending;
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    int   cycle_cnt    = 0;
    logic hold_on      = 1'b0;
    int   crd [NUM_CRD];
    int   tx_mix [4] = '{0, 81, 0, 20};
    int   rx_mix [4] = '{0, 0, 81, 20};

    point_in_triangle_test dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    point_in_triangle_check u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_m_tready <= !hold_on && ($urandom_range(99) >= rx_stall_pct);
    end

    // long output hold while the sender keeps offering beats
    initial begin
        wait (i_rst_n);
        repeat (40) @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYC) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYC) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int rnd_crd(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int clamp(input int v);
        return (v > CRD_MAX) ? CRD_MAX : (v < CRD_MIN) ? CRD_MIN : v;
    endfunction

    task automatic send_beat();
        logic [IN_W-1:0] beat;
        for (int i = 0; i < NUM_CRD; i++)
            beat[i*COORD_W +: COORD_W] = COORD_W'(crd[i]);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= beat;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic set_shape(input int ax, input int ay, input int az,
                             input int bx, input int by, input int bz,
                             input int cx, input int cy, input int cz);
        crd[VTX_A*3] = ax; crd[VTX_A*3+1] = ay; crd[VTX_A*3+2] = az;
        crd[VTX_B*3] = bx; crd[VTX_B*3+1] = by; crd[VTX_B*3+2] = bz;
        crd[VTX_C*3] = cx; crd[VTX_C*3+1] = cy; crd[VTX_C*3+2] = cz;
    endtask

    task automatic probe(input int px, input int py, input int pz);
        crd[VTX_P*3] = px; crd[VTX_P*3+1] = py; crd[VTX_P*3+2] = pz;
        send_beat();
    endtask

    task automatic send_random();
        int mode;
        int wsum;
        int m;
        int j;
        int rot;
        int w [3];
        int d [3];
        int a [3];
        mode = $urandom_range(9);
        case (mode)
            0, 1: begin
                for (int i = 0; i < NUM_CRD; i++)
                    crd[i] = rnd_crd(CRD_MIN, CRD_MAX);
            end
            // point as a weighted blend of the vertices, sometimes nudged
            2, 3, 4: begin
                for (int i = 3; i < NUM_CRD; i++)
                    crd[i] = rnd_crd(CRD_MIN, CRD_MAX);
                wsum = 0;
                for (int v = 0; v < 3; v++) begin
                    w[v] = $urandom_range(255);
                    wsum += w[v];
                end
                if (wsum == 0) begin
                    w[0] = 1;
                    wsum = 1;
                end
                for (int k = 0; k < 3; k++)
                    crd[k] = (w[0] * crd[3+k] + w[1] * crd[6+k] + w[2] * crd[9+k]) / wsum;
                if ($urandom_range(1))
                    for (int k = 0; k < 3; k++)
                        crd[k] = clamp(crd[k] + rnd_crd(-3, 3));
            end
            // small shape with the point close by
            5, 6: begin
                for (int k = 0; k < 3; k++)
                    a[k] = rnd_crd(-30000, 30000);
                for (int i = 0; i < NUM_CRD; i++)
                    crd[i] = a[i % 3] + rnd_crd(-512, 512);
            end
            // point exactly on one edge
            7: begin
                rot = $urandom_range(2);
                m   = $urandom_range(8, 1);
                j   = $urandom_range(m);
                for (int k = 0; k < 3; k++) begin
                    d[k] = rnd_crd(-300, 300);
                    a[k] = rnd_crd(-20000, 20000);
                    crd[k] = a[k] + j * d[k];
                    crd[3 + 3*rot + k] = a[k];
                    crd[3 + 3*((rot + 1) % 3) + k] = a[k] + m * d[k];
                    crd[3 + 3*((rot + 2) % 3) + k] = rnd_crd(CRD_MIN, CRD_MAX);
                end
            end
            // collinear vertices
            8: begin
                for (int k = 0; k < 3; k++) begin
                    d[k] = rnd_crd(-300, 300);
                    a[k] = rnd_crd(-10000, 10000);
                    crd[k] = rnd_crd(CRD_MIN, CRD_MAX);
                end
                for (int v = 0; v < 3; v++) begin
                    m = rnd_crd(-8, 8);
                    for (int k = 0; k < 3; k++)
                        crd[3 + 3*v + k] = a[k] + m * d[k];
                end
            end
            // point sits on a vertex
            default: begin
                for (int i = 3; i < NUM_CRD; i++)
                    crd[i] = rnd_crd(CRD_MIN, CRD_MAX);
                rot = $urandom_range(2);
                for (int k = 0; k < 3; k++)
                    crd[k] = crd[3 + 3*rot + k];
            end
        endcase
        send_beat();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_shape(0, 0, 0, 256, 0, 0, 0, 256, 0);
        probe(64, 64, 0);
        probe(512, 512, 0);
        probe(128, 0, 0);
        probe(256, 0, 0);
        probe(128, 128, 0);
        probe(129, 128, 0);
        probe(128, -1, 0);
        probe(64, 64, 5000);
        // opposite winding
        set_shape(0, 0, 0, 0, 256, 0, 256, 0, 0);
        probe(64, 64, 0);
        probe(-1, 0, 0);
        // degenerate shapes
        set_shape(0, 0, 0, 100, 100, 100, 300, 300, 300);
        probe(-20000, 5, 7);
        set_shape(CRD_MAX, CRD_MIN, 1234, CRD_MAX, CRD_MIN, 1234, CRD_MAX, CRD_MIN, 1234);
        probe(0, 0, 0);
        set_shape(CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN,
                  CRD_MIN, CRD_MIN, CRD_MIN);
        probe(CRD_MIN, CRD_MIN, CRD_MIN);
        set_shape(CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX,
                  CRD_MAX, CRD_MAX, CRD_MAX);
        probe(CRD_MAX, CRD_MAX, CRD_MAX);
        // full-range shapes
        set_shape(CRD_MIN, CRD_MIN, 0, CRD_MAX, CRD_MIN, 0, 0, CRD_MAX, 0);
        probe(0, 0, 0);
        probe(CRD_MAX, CRD_MAX, 0);
        probe(CRD_MIN, CRD_MIN, 0);
        set_shape(CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MIN,
                  CRD_MIN, CRD_MAX, CRD_MAX);
        probe(CRD_MAX, CRD_MIN, CRD_MAX);
        probe(CRD_MIN, CRD_MAX, CRD_MIN);
        // shape in a constant-x plane, point in and off the plane
        set_shape(1000, 0, 0, 1000, 256, 0, 1000, 0, 256);
        probe(1000, 50, 50);
        probe(-1000, 50, 50);

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct   = tx_mix[ph];
            rx_stall_pct <= rx_mix[ph];
            repeat (RAND_PER_PHASE) send_random();
        end
        i_s_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2 * NSTG) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: point_in_triangle_test.f
hw/rtl/pit_pkg.sv
hw/rtl/point_in_triangle_test.sv
hw/rtl/pit_checker.sv
tb/sv/point_in_triangle_check.sv
tb/sv/tb_point_in_triangle_test.sv
